>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define BRTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication.
`define BRTS_ASSERT_NOW(lbl, pre, post, msg) \
  `BRTS_ASSERT(lbl, (pre) |-> (post), msg)

// Next-cycle implication.
`define BRTS_ASSERT_NEXT(lbl, pre, post, msg) \
  `BRTS_ASSERT(lbl, (pre) |=> (post), msg)

`endif

>>> src/brts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brts_pkg
// Shared widths, constants, register map and saturation helper of the
// Bloch-equation RK4 stepper.
// ----------------------------------------------------------------------------
package brts_pkg;

  localparam int unsigned FRAC_BITS      = 30;
  localparam int unsigned INDEX_BITS_DEF = 16;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned RATE_W = 31;
  localparam int unsigned POP_W  = 31;
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  // multiplier operands carry one extra bit for z - zeq and unsigned rates
  localparam int unsigned OPER_W = DATA_W + 1;
  localparam int unsigned PROD_W = 2 * OPER_W;
  localparam int unsigned TERM_W = PROD_W - FRAC_BITS;
  localparam int unsigned ACC_W  = TERM_W + 1;
  // k1 + 2k2 + 2k3 + k4 needs 35 bits; keep a multiple of the divide digit
  localparam int unsigned SUM_W  = DATA_W + 4;

  localparam logic signed [DATA_W-1:0] ONE_FX       = 1 <<< FRAC_BITS;
  localparam logic signed [DATA_W-1:0] MINUS_ONE_FX = -ONE_FX;
  localparam logic signed [DATA_W-1:0] S_MAX        = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN        = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_DETUNING = 3'd0,
    REG_DRIVE    = 3'd1,
    REG_DEPHASE  = 3'd2,
    REG_RELAX    = 3'd3,
    REG_EQ_Z     = 3'd4
  } reg_idx_e;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_e;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(S_MAX)) begin
      return S_MAX;
    end else if (v < ACC_W'(S_MIN)) begin
      return S_MIN;
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

endpackage

>>> src/bloch_rk4_trajectory_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloch_rk4_trajectory_stepper
// Fixed-point RK4 integrator of the Bloch equations with an APB register port.
// ----------------------------------------------------------------------------
// A load transaction sets the Q2.30 Bloch vector and clears the sample index;
// a step transaction advances it by one RK4 step. Every input transaction
// gives one result (vector, excited population, sample index). in_ready_o is
// high only while the sequencer is idle. A load goes from idle straight to
// emit; a step runs four derivative evaluations of 7 products each through
// one shared 33x33 multiplier (one product per cycle, then a drain step and
// a stage-update step per evaluation), then the divide by six at 4 quotient
// bits per cycle, plus prepare, write-back, emit and idle states. The result
// sits in an output register, so the next transaction is taken while it
// waits; the sequencer only stalls in its emit state if the previous result
// has not yet been taken.
module bloch_rk4_trajectory_stepper #(
  parameter int unsigned INDEX_BITS = brts_pkg::INDEX_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [brts_pkg::APB_AW-1:0]         paddr,
  input  logic [brts_pkg::APB_DW-1:0]         pwdata,
  output logic [brts_pkg::APB_DW-1:0]         prdata,
  output logic                                pready,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                action_i,
  input  logic signed [brts_pkg::DATA_W-1:0]  load_x_i,
  input  logic signed [brts_pkg::DATA_W-1:0]  load_y_i,
  input  logic signed [brts_pkg::DATA_W-1:0]  load_z_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [brts_pkg::DATA_W-1:0]  out_x_o,
  output logic signed [brts_pkg::DATA_W-1:0]  out_y_o,
  output logic signed [brts_pkg::DATA_W-1:0]  out_z_o,
  output logic [brts_pkg::POP_W-1:0]          excited_pop_o,
  output logic [INDEX_BITS-1:0]               sample_index_o
);

  localparam int unsigned DATA_W    = brts_pkg::DATA_W;
  localparam int unsigned ACC_W     = brts_pkg::ACC_W;
  localparam int unsigned SUM_W     = brts_pkg::SUM_W;
  localparam int unsigned OPER_W    = brts_pkg::OPER_W;
  localparam int unsigned PROD_W    = brts_pkg::PROD_W;
  localparam int unsigned TERM_W    = brts_pkg::TERM_W;
  localparam int unsigned FRAC_BITS = brts_pkg::FRAC_BITS;
  localparam int unsigned POP_W     = brts_pkg::POP_W;
  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned NUM_OPS   = 7;
  localparam int unsigned OP_W      = $clog2(NUM_OPS + 1);
  localparam int unsigned DIV_W     = SUM_W;
  localparam int unsigned DIGIT     = 4;
  localparam int unsigned DIV_CYC   = DIV_W / DIGIT;
  localparam int unsigned CNT_W     = $clog2((DIV_CYC > NUM_OPS + 1) ? DIV_CYC : NUM_OPS + 1);
  localparam logic [1:0]  LAST_STAGE = 2'd3;
  localparam logic [3:0]  DIVISOR    = 4'd6;
  localparam logic [DIV_W-1:0] RND_BIAS = DIV_W'(3);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_UPD, S_PREP, S_DIV, S_FIN, S_EMIT
  } state_e;

  typedef enum logic [1:0] {C_X, C_Y, C_Z} comp_e;
  typedef enum logic [1:0] {A_DET, A_DRV, A_DEPH, A_RELAX} a_sel_e;
  typedef enum logic [1:0] {B_X, B_Y, B_Z, B_DZ} b_sel_e;

  typedef struct packed {
    logic   neg;
    comp_e  comp;
    logic   last;
    a_sel_e asel;
    b_sel_e bsel;
  } op_info_t;

  // product schedule of one derivative evaluation
  function automatic op_info_t op_info(input logic [OP_W-1:0] idx);
    op_info_t r;
    case (idx)
      3'd0:    r = '{neg: 1'b0, comp: C_X, last: 1'b0, asel: A_DET,   bsel: B_Y};
      3'd1:    r = '{neg: 1'b1, comp: C_X, last: 1'b1, asel: A_DEPH,  bsel: B_X};
      3'd2:    r = '{neg: 1'b1, comp: C_Y, last: 1'b0, asel: A_DET,   bsel: B_X};
      3'd3:    r = '{neg: 1'b0, comp: C_Y, last: 1'b0, asel: A_DRV,   bsel: B_Z};
      3'd4:    r = '{neg: 1'b1, comp: C_Y, last: 1'b1, asel: A_DEPH,  bsel: B_Y};
      3'd5:    r = '{neg: 1'b1, comp: C_Z, last: 1'b0, asel: A_DRV,   bsel: B_Y};
      3'd6:    r = '{neg: 1'b1, comp: C_Z, last: 1'b1, asel: A_RELAX, bsel: B_DZ};
      default: r = '{neg: 1'b0, comp: C_X, last: 1'b0, asel: A_DET,   bsel: B_X};
    endcase
    return r;
  endfunction

  // configuration registers
  logic signed [DATA_W-1:0]           detuning_q, drive_q, eq_z_q;
  logic [brts_pkg::RATE_W-1:0]        dephase_q, relax_q;
  logic [2:0]                         cfg_idx;
  logic                               cfg_wr;

  // sequencer and architectural state
  state_e                             state_q;
  logic [CNT_W-1:0]                   cnt_q;
  logic [1:0]                         st_q;
  logic [INDEX_BITS-1:0]              count_q;
  logic signed [DATA_W-1:0]           vec_q [NUM_LANES];

  // output register
  logic                               out_valid_q;
  logic signed [DATA_W-1:0]           out_x_q, out_y_q, out_z_q;
  logic [POP_W-1:0]                   out_pop_q;
  logic [INDEX_BITS-1:0]              out_idx_q;

  // datapath
  logic signed [OPER_W-1:0]           op_a, op_b, dz_q;
  logic signed [PROD_W-1:0]           prod_q;
  logic signed [TERM_W-1:0]           term_trunc;
  logic signed [ACC_W-1:0]            term_ext, addend, acc_q, acc_sum;
  logic                               cin;
  op_info_t                           issue_op, acc_op;
  logic signed [DATA_W-1:0]           t_q   [NUM_LANES];
  logic signed [DATA_W-1:0]           k_q   [NUM_LANES];
  logic signed [SUM_W-1:0]            sum_q [NUM_LANES];
  logic [DIV_W-1:0]                   num_q [NUM_LANES];
  logic [2:0]                         rem_q [NUM_LANES];
  logic                               neg_q [NUM_LANES];
  logic signed [DATA_W-1:0]           t_next   [NUM_LANES];
  logic signed [SUM_W-1:0]            sum_next [NUM_LANES];
  logic [DIV_W-1:0]                   prep_num [NUM_LANES];
  logic [DIV_W-1:0]                   div_num  [NUM_LANES];
  logic [2:0]                         div_rem  [NUM_LANES];
  logic signed [DATA_W-1:0]           fin_vec  [NUM_LANES];
  logic signed [DATA_W:0]             pop_sum, pop_half;
  logic [POP_W-1:0]                   pop_d;

  // --------------------------------------------------------------------------
  // APB register file
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[brts_pkg::APB_AW-1:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detuning_q <= '0;
      drive_q    <= '0;
      dephase_q  <= '0;
      relax_q    <= '0;
      eq_z_q     <= brts_pkg::MINUS_ONE_FX;
    end else if (cfg_wr) begin
      case (brts_pkg::reg_idx_e'(cfg_idx))
        brts_pkg::REG_DETUNING: detuning_q <= pwdata[DATA_W-1:0];
        brts_pkg::REG_DRIVE:    drive_q    <= pwdata[DATA_W-1:0];
        brts_pkg::REG_DEPHASE:  dephase_q  <= pwdata[brts_pkg::RATE_W-1:0];
        brts_pkg::REG_RELAX:    relax_q    <= pwdata[brts_pkg::RATE_W-1:0];
        brts_pkg::REG_EQ_Z:     eq_z_q     <= pwdata[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (brts_pkg::reg_idx_e'(cfg_idx))
      brts_pkg::REG_DETUNING: prdata = detuning_q;
      brts_pkg::REG_DRIVE:    prdata = drive_q;
      brts_pkg::REG_DEPHASE:  prdata = {1'b0, dephase_q};
      brts_pkg::REG_RELAX:    prdata = {1'b0, relax_q};
      brts_pkg::REG_EQ_Z:     prdata = eq_z_q;
      default:                prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // shared multiplier and derivative accumulator
  // --------------------------------------------------------------------------
  assign issue_op = op_info(cnt_q[OP_W-1:0]);
  assign acc_op   = op_info(OP_W'(cnt_q[OP_W-1:0] - 1'b1));

  always_comb begin
    case (issue_op.asel)
      A_DET:   op_a = OPER_W'(detuning_q);
      A_DRV:   op_a = OPER_W'(drive_q);
      A_DEPH:  op_a = {2'b00, dephase_q};
      A_RELAX: op_a = {2'b00, relax_q};
      default: op_a = '0;
    endcase
    case (issue_op.bsel)
      B_X:     op_b = OPER_W'(t_q[C_X]);
      B_Y:     op_b = OPER_W'(t_q[C_Y]);
      B_Z:     op_b = OPER_W'(t_q[C_Z]);
      B_DZ:    op_b = dz_q;
      default: op_b = '0;
    endcase
  end

  // round half up: truncated product plus bit FRAC_BITS-1; a subtraction
  // folds that bit into the carry of acc + ~term
  assign term_trunc = prod_q[PROD_W-1:FRAC_BITS];
  assign term_ext   = term_trunc;
  assign addend     = acc_op.neg ? ~term_ext : term_ext;
  assign cin        = acc_op.neg ^ prod_q[FRAC_BITS-1];
  assign acc_sum    = acc_q + addend + ACC_W'(cin);

  // --------------------------------------------------------------------------
  // per-component lanes: stage vectors, RK sum, divide by six, write back
  // --------------------------------------------------------------------------
  always_comb begin
    logic signed [DATA_W-1:0] stage_k;
    logic signed [ACC_W-1:0]  upd_sum;
    logic signed [SUM_W-1:0]  k_ext;
    logic signed [ACC_W-1:0]  q_ext;
    logic signed [ACC_W-1:0]  fin_sum;
    logic [DIGIT:0]           trial;
    logic [2:0]               r;
    logic [DIV_W-1:0]         n;
    for (int i = 0; i < NUM_LANES; i++) begin
      stage_k   = (st_q == 2'd2) ? k_q[i] : (k_q[i] >>> 1);
      upd_sum   = ACC_W'(vec_q[i]) + ACC_W'(stage_k);
      t_next[i] = brts_pkg::sat32(upd_sum);

      k_ext = SUM_W'(k_q[i]);
      if (st_q == 2'd0) begin
        sum_next[i] = k_ext;
      end else if (st_q == LAST_STAGE) begin
        sum_next[i] = sum_q[i] + k_ext;
      end else begin
        sum_next[i] = sum_q[i] + (k_ext <<< 1);
      end

      // magnitude plus 3, so the quotient rounds half away from zero
      prep_num[i] = sum_q[i][SUM_W-1] ? (~sum_q[i]) + (RND_BIAS + 1'b1)
                                      : sum_q[i] + RND_BIAS;

      // restoring division by six, one quotient bit per step
      r = rem_q[i];
      n = num_q[i];
      for (int j = 0; j < DIGIT; j++) begin
        trial = {1'b0, r, n[DIV_W-1]};
        n     = {n[DIV_W-2:0], 1'b0};
        if (trial >= {1'b0, DIVISOR}) begin
          trial = trial - {1'b0, DIVISOR};
          n[0]  = 1'b1;
        end
        r = trial[2:0];
      end
      div_num[i] = n;
      div_rem[i] = r;

      q_ext      = $signed({1'b0, num_q[i]});
      fin_sum    = neg_q[i] ? ACC_W'(vec_q[i]) - q_ext : ACC_W'(vec_q[i]) + q_ext;
      fin_vec[i] = brts_pkg::sat32(fin_sum);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    dz_q   <= OPER_W'(t_q[C_Z]) - OPER_W'(eq_z_q);
    case (state_q)
      S_IDLE: begin
        for (int i = 0; i < NUM_LANES; i++) t_q[i] <= vec_q[i];
        acc_q <= '0;
      end
      S_MUL: begin
        if (cnt_q != '0) begin
          if (acc_op.last) begin
            k_q[acc_op.comp] <= brts_pkg::sat32(acc_sum);
            acc_q            <= '0;
          end else begin
            acc_q <= acc_sum;
          end
        end
      end
      S_UPD: begin
        for (int i = 0; i < NUM_LANES; i++) begin
          t_q[i]   <= t_next[i];
          sum_q[i] <= sum_next[i];
        end
        acc_q <= '0;
      end
      S_PREP: begin
        for (int i = 0; i < NUM_LANES; i++) begin
          neg_q[i] <= sum_q[i][SUM_W-1];
          num_q[i] <= prep_num[i];
          rem_q[i] <= '0;
        end
      end
      S_DIV: begin
        for (int i = 0; i < NUM_LANES; i++) begin
          num_q[i] <= div_num[i];
          rem_q[i] <= div_rem[i];
        end
      end
      default: ;
    endcase
  end

  // excited population (1 + z) / 2, floored, clamped to 0..1
  assign pop_sum  = (DATA_W+1)'(brts_pkg::ONE_FX) + (DATA_W+1)'(vec_q[C_Z]);
  assign pop_half = pop_sum >>> 1;

  always_comb begin
    if (pop_half[DATA_W]) begin
      pop_d = '0;
    end else if (pop_half > (DATA_W+1)'(brts_pkg::ONE_FX)) begin
      pop_d = brts_pkg::ONE_FX[POP_W-1:0];
    end else begin
      pop_d = pop_half[POP_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      st_q        <= '0;
      count_q     <= '0;
      vec_q[C_X]  <= '0;
      vec_q[C_Y]  <= '0;
      vec_q[C_Z]  <= brts_pkg::MINUS_ONE_FX;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_z_q     <= '0;
      out_pop_q   <= '0;
      out_idx_q   <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (brts_pkg::action_e'(action_i) == brts_pkg::ACT_LOAD) begin
              vec_q[C_X] <= load_x_i;
              vec_q[C_Y] <= load_y_i;
              vec_q[C_Z] <= load_z_i;
              count_q    <= '0;
              state_q    <= S_EMIT;
            end else begin
              cnt_q   <= '0;
              st_q    <= '0;
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (cnt_q == CNT_W'(NUM_OPS)) begin
            cnt_q   <= '0;
            state_q <= S_UPD;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_UPD: begin
          st_q    <= st_q + 1'b1;
          state_q <= (st_q == LAST_STAGE) ? S_PREP : S_MUL;
        end
        S_PREP: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (cnt_q == CNT_W'(DIV_CYC - 1)) begin
            cnt_q   <= '0;
            state_q <= S_FIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_FIN: begin
          for (int i = 0; i < NUM_LANES; i++) vec_q[i] <= fin_vec[i];
          count_q <= count_q + 1'b1;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_x_q     <= vec_q[C_X];
            out_y_q     <= vec_q[C_Y];
            out_z_q     <= vec_q[C_Z];
            out_pop_q   <= pop_d;
            out_idx_q   <= count_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign out_x_o        = out_x_q;
  assign out_y_o        = out_y_q;
  assign out_z_o        = out_z_q;
  assign excited_pop_o  = out_pop_q;
  assign sample_index_o = out_idx_q;

endmodule

>>> src/brts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brts_checker
// Port-level assertions for the RK4 stepper, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brts_checker #(
  parameter int unsigned INDEX_BITS = brts_pkg::INDEX_BITS_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               psel,
  input logic                               penable,
  input logic                               pwrite,
  input logic [brts_pkg::APB_AW-1:0]        paddr,
  input logic [brts_pkg::APB_DW-1:0]        pwdata,
  input logic [brts_pkg::APB_DW-1:0]        prdata,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [brts_pkg::DATA_W-1:0] out_x_o,
  input logic signed [brts_pkg::DATA_W-1:0] out_y_o,
  input logic signed [brts_pkg::DATA_W-1:0] out_z_o,
  input logic [brts_pkg::POP_W-1:0]         excited_pop_o,
  input logic [INDEX_BITS-1:0]              sample_index_o
);

  localparam logic [brts_pkg::POP_W-1:0] POP_MAX = brts_pkg::ONE_FX[brts_pkg::POP_W-1:0];

  logic det_wr, det_rd;

  assign det_wr = psel & penable & pwrite &
                  (paddr[brts_pkg::APB_AW-1:2] == brts_pkg::REG_DETUNING);
  assign det_rd = psel & !pwrite & (paddr[brts_pkg::APB_AW-1:2] == brts_pkg::REG_DETUNING);

  // the sequencer leaves idle on every accepted transaction
  `BRTS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready stayed high after accept")

  // a stalled result holds
  `BRTS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_x_o) && $stable(out_y_o) && $stable(out_z_o) && $stable(excited_pop_o) && $stable(sample_index_o), "result changed under stall")

  // population saturates at 1.0
  `BRTS_ASSERT_NOW(a_pop_range, out_valid_o, excited_pop_o <= POP_MAX, "excited population above one")

  // a detuning read right after its write returns the written data
  `BRTS_ASSERT_NOW(a_cfg_readback, det_rd && $past(det_wr), prdata == $past(pwdata), "detuning readback mismatch")

endmodule

bind bloch_rk4_trajectory_stepper brts_checker #(.INDEX_BITS(INDEX_BITS)) u_brts_checker (.*);

>>> sim/bloch_traj_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloch_traj_checker
// Watches the register port and both streams of the Bloch RK4 stepper. It
// keeps its own copy of the rates and the Bloch vector, predicts each sample
// on input acceptance and compares the emitted samples in order.
// ----------------------------------------------------------------------------
module bloch_traj_checker #(
  parameter int unsigned INDEX_BITS = brts_pkg::INDEX_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel_i,
  input  logic                               penable_i,
  input  logic                               pwrite_i,
  input  logic                               pready_i,
  input  logic [brts_pkg::APB_AW-1:0]        paddr_i,
  input  logic [brts_pkg::APB_DW-1:0]        pwdata_i,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic                               action_i,
  input  logic signed [brts_pkg::DATA_W-1:0] load_x_i,
  input  logic signed [brts_pkg::DATA_W-1:0] load_y_i,
  input  logic signed [brts_pkg::DATA_W-1:0] load_z_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic signed [brts_pkg::DATA_W-1:0] out_x_i,
  input  logic signed [brts_pkg::DATA_W-1:0] out_y_i,
  input  logic signed [brts_pkg::DATA_W-1:0] out_z_i,
  input  logic [brts_pkg::POP_W-1:0]         excited_pop_i,
  input  logic [INDEX_BITS-1:0]              sample_index_i,
  output int                                 mismatches_o,
  output int                                 pending_o
);
  import brts_pkg::*;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } bloch_t;

  typedef struct {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic [POP_W-1:0]         pop;
    logic [INDEX_BITS-1:0]    idx;
  } sample_t;

  localparam longint UNIT  = longint'(1) <<< FRAC_BITS;
  localparam longint W_MAX = 2147483647;
  localparam longint W_MIN = -W_MAX - 1;

  longint                detune;
  longint                drive;
  longint                dephase;
  longint                relax;
  longint                z_eq;
  bloch_t                vec;
  logic [INDEX_BITS-1:0] steps;
  sample_t               samples_q[$];

  initial mismatches_o = 0;

  function automatic longint clamp32(input longint v);
    if (v > W_MAX) return W_MAX;
    if (v < W_MIN) return W_MIN;
    return v;
  endfunction

  // Q2.30 product, round half up
  function automatic longint fx_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    return (p >>> FRAC_BITS) + (p[FRAC_BITS-1] ? 64'sd1 : 64'sd0);
  endfunction

  function automatic bloch_t rates_at(input bloch_t s);
    bloch_t k;
    k.x = clamp32(fx_mul(detune, s.y) - fx_mul(dephase, s.x));
    k.y = clamp32(-fx_mul(detune, s.x) + fx_mul(drive, s.z) - fx_mul(dephase, s.y));
    k.z = clamp32(-fx_mul(drive, s.y) - fx_mul(relax, s.z - z_eq));
    return k;
  endfunction

  // intermediate stage point: s + k/2 (floor) or s + k
  function automatic bloch_t nudge(input bloch_t s, input bloch_t k, input int sh);
    bloch_t t;
    t.x = clamp32(s.x + (k.x >>> sh));
    t.y = clamp32(s.y + (k.y >>> sh));
    t.z = clamp32(s.z + (k.z >>> sh));
    return t;
  endfunction

  // divide by six, nearest, ties away from zero
  function automatic longint sixth(input longint acc);
    return (acc >= 0) ? (acc + 3) / 6 : (acc - 3) / 6;
  endfunction

  function automatic bloch_t rk4_advance(input bloch_t s);
    bloch_t k1, k2, k3, k4, n;
    k1 = rates_at(s);
    k2 = rates_at(nudge(s, k1, 1));
    k3 = rates_at(nudge(s, k2, 1));
    k4 = rates_at(nudge(s, k3, 0));
    n.x = clamp32(s.x + sixth(k1.x + 2 * k2.x + 2 * k3.x + k4.x));
    n.y = clamp32(s.y + sixth(k1.y + 2 * k2.y + 2 * k3.y + k4.y));
    n.z = clamp32(s.z + sixth(k1.z + 2 * k2.z + 2 * k3.z + k4.z));
    return n;
  endfunction

  task automatic check_field(input string label, input longint want, input longint got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d got %0d", $time, label, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t want;
    longint  pop;
    if (!rst_ni) begin
      detune  = 0;
      drive   = 0;
      dephase = 0;
      relax   = 0;
      z_eq    = -UNIT;
      vec.x   = 0;
      vec.y   = 0;
      vec.z   = -UNIT;
      steps   = '0;
      samples_q.delete();
      pending_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[APB_AW-1:2])
          REG_DETUNING: detune  = longint'($signed(pwdata_i));
          REG_DRIVE:    drive   = longint'($signed(pwdata_i));
          REG_DEPHASE:  dephase = longint'(pwdata_i[RATE_W-1:0]);
          REG_RELAX:    relax   = longint'(pwdata_i[RATE_W-1:0]);
          REG_EQ_Z:     z_eq    = longint'($signed(pwdata_i));
          default: ;
        endcase
      end

      // compare before predicting: a sample leaving now is never the one entering
      if (out_valid_i && out_ready_i) begin
        if (samples_q.size() == 0) begin
          $display("%0t ns: sample with none expected, x %0d y %0d z %0d index %0d",
                   $time, out_x_i, out_y_i, out_z_i, sample_index_i);
          mismatches_o++;
        end else begin
          want = samples_q.pop_front();
          check_field("out_x", want.x, out_x_i);
          check_field("out_y", want.y, out_y_i);
          check_field("out_z", want.z, out_z_i);
          check_field("excited_pop", want.pop, excited_pop_i);
          check_field("sample_index", want.idx, sample_index_i);
        end
      end

      if (in_valid_i && in_ready_i) begin
        if (action_i == ACT_LOAD) begin
          vec.x = load_x_i;
          vec.y = load_y_i;
          vec.z = load_z_i;
          steps = '0;
        end else begin
          vec   = rk4_advance(vec);
          steps = steps + 1'b1;
        end
        pop = (UNIT + vec.z) >>> 1;
        if (pop < 0) begin
          pop = 0;
        end else if (pop > UNIT) begin
          pop = UNIT;
        end
        want.x   = vec.x[DATA_W-1:0];
        want.y   = vec.y[DATA_W-1:0];
        want.z   = vec.z[DATA_W-1:0];
        want.pop = pop[POP_W-1:0];
        want.idx = steps;
        samples_q.push_back(want);
      end
      pending_o = samples_q.size();
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the Bloch RK4 trajectory stepper: directed loads
// and steps at the range ends and saturating rates, then random phases with
// reprogrammed rates, random idles on both streams, a long output hold-off
// and drain pauses. Checking is done by bloch_traj_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import brts_pkg::*;

  typedef enum logic [1:0] {
    RATES_GENTLE = 2'd0,
    RATES_WILD   = 2'd1,
    RATES_SPARSE = 2'd2
  } rate_mix_e;

  localparam logic [2:0]  UNMAPPED_FIRST = 3'd5;
  localparam logic [2:0]  UNMAPPED_LAST  = 3'd7;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 64;
  localparam int unsigned LIMIT          = 1_000_000;
  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned PHASE_ITEMS    = 250;

  logic                     clk   = 1'b0;
  logic                     rst_n = 1'b0;

  logic                     psel    = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite  = 1'b0;
  logic [APB_AW-1:0]        paddr   = '0;
  logic [APB_DW-1:0]        pwdata  = '0;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  action_e                  action   = ACT_LOAD;
  logic signed [DATA_W-1:0] load_x   = '0;
  logic signed [DATA_W-1:0] load_y   = '0;
  logic signed [DATA_W-1:0] load_z   = '0;

  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_x;
  logic signed [DATA_W-1:0] out_y;
  logic signed [DATA_W-1:0] out_z;
  logic [POP_W-1:0]         excited_pop;
  logic [INDEX_BITS_DEF-1:0] sample_index;

  int                       mismatches;
  int                       pending;
  bit                       calm      = 1'b0;
  logic                     hold_tgl  = 1'b0;
  logic                     hold_seen = 1'b0;
  int unsigned              hold_left = 0;
  int unsigned              cycle_cnt = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  bloch_rk4_trajectory_stepper u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .action_i       (action),
    .load_x_i       (load_x),
    .load_y_i       (load_y),
    .load_z_i       (load_z),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_x_o        (out_x),
    .out_y_o        (out_y),
    .out_z_o        (out_z),
    .excited_pop_o  (excited_pop),
    .sample_index_o (sample_index)
  );

  bloch_traj_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .action_i       (action),
    .load_x_i       (load_x),
    .load_y_i       (load_y),
    .load_z_i       (load_z),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_x_i        (out_x),
    .out_y_i        (out_y),
    .out_z_i        (out_z),
    .excited_pop_i  (excited_pop),
    .sample_index_i (sample_index),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  // result side: random idles, plus a long hold-off whenever hold_tgl flips
  always @(posedge clk) begin
    if (hold_tgl != hold_seen) begin
      hold_seen <= hold_tgl;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic logic [31:0] around_zero(input int unsigned mag);
    return $urandom_range(2 * mag) - mag;
  endfunction

  // half the loads stay on the unit range, half use any 32-bit word
  function automatic logic [31:0] coord();
    if ($urandom_range(1) == 0) return $urandom;
    return around_zero(ONE_FX);
  endfunction

  // leaves valid high on return; the caller's next step decides what follows
  task automatic offer(input action_e act, input logic [31:0] x, input logic [31:0] y,
                       input logic [31:0] z);
    if (!calm) begin
      while ($urandom_range(99) < 11) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    action   <= act;
    load_x   <= x;
    load_y   <= y;
    load_z   <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic step_n(input int n);
    repeat (n) offer(ACT_STEP, $urandom, $urandom, $urandom);
  endtask

  // first look after the next edge so the transaction just accepted is counted
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic program_rates(input logic [31:0] d, input logic [31:0] w,
                               input logic [31:0] g2, input logic [31:0] g1,
                               input logic [31:0] zeq, input bit poke_unmapped);
    write_reg(REG_DETUNING, d);
    write_reg(REG_DRIVE, w);
    write_reg(REG_DEPHASE, g2);
    write_reg(REG_RELAX, g1);
    write_reg(REG_EQ_Z, zeq);
    if (poke_unmapped) begin
      write_reg(UNMAPPED_FIRST, $urandom);
      write_reg(UNMAPPED_LAST, $urandom);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    rate_mix_e   mix;
    logic [31:0] d, w, g2, g1, zeq;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset rates: vector from reset, range ends, population clamps
    step_n(1);
    offer(ACT_LOAD, S_MAX, S_MIN, S_MAX);
    step_n(1);
    offer(ACT_LOAD, S_MIN, S_MAX, S_MIN);
    step_n(1);
    offer(ACT_LOAD, '0, '0, ONE_FX);
    offer(ACT_LOAD, '0, '0, MINUS_ONE_FX + 1);

    // strongest rates, top bit of the 31-bit rates set, writes off the map
    wait_for_results();
    program_rates(S_MAX, S_MAX, '1, '1, S_MIN, 1'b1);
    offer(ACT_LOAD, S_MAX, S_MAX, S_MAX);
    step_n(2);
    offer(ACT_LOAD, S_MIN, S_MIN, S_MIN);
    step_n(2);

    // most negative rates, both decays disabled
    wait_for_results();
    program_rates(S_MIN, S_MIN, '0, '0, S_MAX, 1'b0);
    offer(ACT_LOAD, ONE_FX, '0, '0);
    step_n(2);
    offer(ACT_LOAD, S_MAX, S_MIN, '0);
    step_n(1);

    // plain Rabi flop from the ground state
    wait_for_results();
    program_rates(ONE_FX >>> 6, ONE_FX >>> 4, '0, ONE_FX >>> 7, MINUS_ONE_FX, 1'b0);
    offer(ACT_LOAD, '0, '0, MINUS_ONE_FX);
    step_n(3);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_for_results();
      mix = rate_mix_e'(ph % 3);
      if (mix == RATES_WILD) begin
        d   = $urandom;
        w   = $urandom;
        g2  = $urandom;
        g1  = $urandom;
        zeq = $urandom;
      end else begin
        d   = around_zero(1 << 27);
        w   = around_zero(1 << 27);
        g2  = $urandom_range(1 << 24);
        g1  = $urandom_range(1 << 24);
        zeq = around_zero(ONE_FX);
        if (mix == RATES_SPARSE) begin
          if ($urandom_range(1) == 1) g2 = '0;
          if ($urandom_range(1) == 1) g1 = '0;
        end
      end
      program_rates(d, w, g2, g1, zeq, ph == 0);
      calm = (ph == 2);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // back up the result side while the sender keeps offering
        if (ph == 4 && n == 30) hold_tgl <= ~hold_tgl;
        if (ph == 5 && n == 125) wait_for_results();
        if ($urandom_range(99) < 10) begin
          offer(ACT_LOAD, coord(), coord(), coord());
        end else begin
          offer(ACT_STEP, $urandom, $urandom, $urandom);
        end
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
